@@ sv/hex_literal_parser_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hex literal parser
// Clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEX_LITERAL_PARSER_TOP_ASSERT_SVH
`define HEX_LITERAL_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define HLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hex literal parser check failed");

// next-cycle implication
`define HLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hex literal parser check failed");

`endif

@@ sv/hlp_pkg.sv @@
// ----------------------------------------------------------------------------
// hlp_pkg
// Types and constants for the hex literal parser.
// ----------------------------------------------------------------------------
package hlp_pkg;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_AFTER_ZERO,
    MODE_HEX0X,
    MODE_AT_LIMIT,
    MODE_EXPECT_QUOTE,
    MODE_HEXQ,
    MODE_RAW,
    MODE_DRAIN
  } hlp_mode_t;

  typedef struct packed {
    logic        is_final;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [12:0] length;
  } hlp_result_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] DIGIT_TEN  = 8'd10;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_HEX  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  localparam int unsigned LEN_FIELD_MAX    = 8191;
  localparam logic [12:0] MAX_LENGTH_RESET = 13'd4096;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    v  = 8'd0;
    ok = 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v  = c - CH_ZERO;
      ok = 1'b1;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      v  = c - CH_UPPER_A + DIGIT_TEN;
      ok = 1'b1;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      v  = c - CH_LOWER_A + DIGIT_TEN;
      ok = 1'b1;
    end
    return {ok, v[3:0]};
  endfunction

endpackage

@@ sv/hlp_in_if.sv @@
// ----------------------------------------------------------------------------
// hlp_in_if
// Character channel: one character per item.
// ----------------------------------------------------------------------------
interface hlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

@@ sv/hlp_out_if.sv @@
// ----------------------------------------------------------------------------
// hlp_out_if
// Result channel: data byte or final status per item.
// ----------------------------------------------------------------------------
interface hlp_out_if;
  logic        valid;
  logic        ready;
  logic        is_final;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [12:0] length;

  modport source (output valid, output is_final, output out_byte, output status,
                  output length, input ready);
  modport sink (input valid, input is_final, input out_byte, input status,
                input length, output ready);
endinterface

@@ sv/hex_literal_parser_top.sv @@
// ----------------------------------------------------------------------------
// hex_literal_parser_top
// Streaming hex literal decoder: 0x form, X'..' form and raw text copy.
// ----------------------------------------------------------------------------
// Results of an item are in the output queue in the cycle after it is accepted.
// Throughput: one character per cycle while ready is high; a terminator that flushes
//   a byte gives two results, delivered from the four-entry result queue.
// Ready is high while the result queue has at least two free entries.
// Reset (rst, synchronous): clears the parse state and the queue, max_length to 4096.
// ----------------------------------------------------------------------------
`include "hex_literal_parser_top_assert.svh"

module hex_literal_parser_top
  import hlp_pkg::*;
#(
  parameter int unsigned LENGTH_LIMIT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  hlp_in_if.sink      chars,
  hlp_out_if.source   results,
  input  logic        wr_en,
  input  logic [12:0] wr_data
);

  localparam int unsigned LimCap =
    (LENGTH_LIMIT < LEN_FIELD_MAX) ? LENGTH_LIMIT : LEN_FIELD_MAX;
  localparam logic [12:0] LIM_CAP = 13'(LimCap);

  logic [12:0] max_length;
  hlp_mode_t   mode, mode_next;
  logic        pend, pend_next;
  logic [3:0]  hi, hi_next;
  logic [13:0] byte_count, byte_count_next;
  logic [1:0]  held, held_next;

  hlp_result_t q [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  fill;

  logic        accept, pop;
  logic [12:0] lim13;
  logic [13:0] lim, cnt_inc;
  logic [4:0]  dig;
  logic        dig_ok;
  logic [3:0]  dval;
  logic        is_nul;

  logic [1:0]  nres;
  hlp_result_t res0, res1;

  assign chars.ready = (fill < 3'd3);
  assign accept      = chars.valid && chars.ready;
  assign pop         = results.valid && results.ready;

  assign lim13   = (max_length == 13'd0) ? 13'd1 :
                   ((max_length > LIM_CAP) ? LIM_CAP : max_length);
  assign lim     = {1'b0, lim13};
  assign cnt_inc = byte_count + 14'd1;
  assign dig     = hex_digit(chars.ch);
  assign dig_ok  = dig[4];
  assign dval    = dig[3:0];
  assign is_nul  = (chars.ch == CH_NUL);

  // next state
  always_comb begin
    mode_next       = mode;
    pend_next       = pend;
    hi_next         = hi;
    byte_count_next = byte_count;
    held_next       = held;
    if (accept) begin
      if (is_nul) begin
        mode_next       = MODE_START;
        pend_next       = 1'b0;
        hi_next         = 4'd0;
        byte_count_next = 14'd0;
        held_next       = STATUS_OK;
      end else begin
        unique case (mode)
          MODE_START: begin
            if (chars.ch == CH_ZERO) begin
              mode_next = MODE_AFTER_ZERO;
            end else if (chars.ch == CH_LOWER_X || chars.ch == CH_UPPER_X) begin
              mode_next = MODE_EXPECT_QUOTE;
            end else begin
              byte_count_next = 14'd1;
              mode_next       = MODE_RAW;
            end
          end
          MODE_AFTER_ZERO: begin
            mode_next = MODE_HEX0X;
            if (chars.ch != CH_LOWER_X) begin
              // leading zero is the high nibble
              pend_next = 1'b1;
              hi_next   = 4'd0;
              if (!dig_ok) begin
                held_next = STATUS_BAD_HEX;
                mode_next = MODE_DRAIN;
              end else begin
                byte_count_next = cnt_inc;
                pend_next       = 1'b0;
                if (cnt_inc >= lim) mode_next = MODE_AT_LIMIT;
              end
            end
          end
          MODE_HEX0X: begin
            if (!dig_ok) begin
              held_next = STATUS_BAD_HEX;
              mode_next = MODE_DRAIN;
            end else if (pend) begin
              byte_count_next = cnt_inc;
              pend_next       = 1'b0;
              if (cnt_inc >= lim) mode_next = MODE_AT_LIMIT;
            end else begin
              hi_next   = dval;
              pend_next = 1'b1;
            end
          end
          MODE_AT_LIMIT: begin
            held_next = STATUS_BAD_HEX;
            mode_next = MODE_DRAIN;
          end
          MODE_EXPECT_QUOTE: begin
            if (chars.ch == CH_QUOTE) begin
              mode_next = MODE_HEXQ;
            end else begin
              held_next = STATUS_BAD_HEX;
              mode_next = MODE_DRAIN;
            end
          end
          MODE_HEXQ: begin
            if (chars.ch == CH_QUOTE) begin
              if (pend) begin
                byte_count_next = cnt_inc;
                pend_next       = 1'b0;
              end
              held_next = STATUS_OK;
              mode_next = MODE_DRAIN;
            end else if (!dig_ok) begin
              held_next = STATUS_BAD_HEX;
              mode_next = MODE_DRAIN;
            end else if (pend) begin
              byte_count_next = cnt_inc;
              pend_next       = 1'b0;
              if (cnt_inc >= lim) begin
                held_next = STATUS_OK;
                mode_next = MODE_DRAIN;
              end
            end else begin
              hi_next   = dval;
              pend_next = 1'b1;
            end
          end
          MODE_RAW: begin
            if (byte_count >= lim) begin
              held_next = STATUS_TOO_LONG;
              mode_next = MODE_DRAIN;
            end else begin
              byte_count_next = cnt_inc;
            end
          end
          MODE_DRAIN: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // results of the accepted item
  always_comb begin
    hlp_result_t fin;
    logic [1:0]  st;
    logic [13:0] cnt;
    nres = 2'd0;
    res0 = '0;
    res1 = '0;
    fin  = '0;
    st   = STATUS_OK;
    cnt  = byte_count;
    if (accept) begin
      if (is_nul) begin
        unique case (mode)
          MODE_AFTER_ZERO: begin
            nres = 2'd1;
            cnt  = cnt_inc;
          end
          MODE_HEX0X, MODE_HEXQ: begin
            if (pend) begin
              res0.out_byte = {hi, 4'd0};
              nres          = 2'd1;
              cnt           = cnt_inc;
            end
          end
          MODE_EXPECT_QUOTE: st = STATUS_BAD_HEX;
          MODE_DRAIN:        st = held;
          default: begin
          end
        endcase
        fin.is_final = 1'b1;
        fin.status   = st;
        fin.length   = (st == STATUS_OK) ? cnt[12:0] : 13'd0;
        if (nres == 2'd0) begin
          res0 = fin;
        end else begin
          res1 = fin;
        end
        nres = nres + 2'd1;
      end else begin
        unique case (mode)
          MODE_START: begin
            if (chars.ch != CH_ZERO && chars.ch != CH_LOWER_X &&
                chars.ch != CH_UPPER_X) begin
              res0.out_byte = chars.ch;
              nres          = 2'd1;
            end
          end
          MODE_AFTER_ZERO: begin
            if (chars.ch != CH_LOWER_X && dig_ok) begin
              res0.out_byte = {4'd0, dval};
              nres          = 2'd1;
            end
          end
          MODE_HEX0X: begin
            if (dig_ok && pend) begin
              res0.out_byte = {hi, dval};
              nres          = 2'd1;
            end
          end
          MODE_HEXQ: begin
            if (chars.ch == CH_QUOTE) begin
              if (pend) begin
                res0.out_byte = {hi, 4'd0};
                nres          = 2'd1;
              end
            end else if (dig_ok && pend) begin
              res0.out_byte = {hi, dval};
              nres          = 2'd1;
            end
          end
          MODE_RAW: begin
            if (byte_count < lim) begin
              res0.out_byte = chars.ch;
              nres          = 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
      mode       <= MODE_START;
      pend       <= 1'b0;
      hi         <= 4'd0;
      byte_count <= 14'd0;
      held       <= STATUS_OK;
      wr_ptr     <= 2'd0;
      rd_ptr     <= 2'd0;
      fill       <= 3'd0;
    end else begin
      if (wr_en) max_length <= wr_data;
      mode       <= mode_next;
      pend       <= pend_next;
      hi         <= hi_next;
      byte_count <= byte_count_next;
      held       <= held_next;
      wr_ptr     <= wr_ptr + nres;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill       <= fill + {1'b0, nres} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (nres != 2'd0) q[wr_ptr] <= res0;
    if (nres == 2'd2) q[wr_ptr + 2'd1] <= res1;
  end

  assign results.valid    = (fill != 3'd0);
  assign results.is_final = q[rd_ptr].is_final;
  assign results.out_byte = q[rd_ptr].out_byte;
  assign results.status   = q[rd_ptr].status;
  assign results.length   = q[rd_ptr].length;

  `HLP_ASSERT_NOW(a_fill_bound, 1'b1, fill <= 3'd4)
  `HLP_ASSERT_NOW(a_two_only_at_end, accept && nres == 2'd2, is_nul)
  `HLP_ASSERT_NOW(a_drain_quiet, accept && mode == MODE_DRAIN && !is_nul, nres == 2'd0)
  `HLP_ASSERT_NEXT(a_end_clears, accept && is_nul, mode == MODE_START && byte_count == 14'd0)

endmodule
